// ===== rtl/cpba_pkg.sv =====
// Shared types and constants for the contiguous page bitmap allocator.
// Used by cpba_ctrl, cpba_datapath and the top level.
package cpba_pkg;

	// Pool geometry
	localparam int MAX_PAGES  = 4096;
	localparam int PAGE_W     = 13;             // page counts 0..MAX_PAGES
	localparam int PG_IDX_W   = 12;             // page index 0..MAX_PAGES-1
	localparam int WORD_BITS  = 16;             // pages per bitmap row
	localparam int LANE_W     = 4;
	localparam int NUM_WORDS  = MAX_PAGES / WORD_BITS;
	localparam int WADDR_W    = PG_IDX_W - LANE_W;
	localparam int CNT_W      = LANE_W + 1;

	// Addressing
	localparam int ADDR_W     = 32;
	localparam int PAGE_SHIFT = 12;             // 4096-byte pages

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_VIRTUAL_BASE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POOL_PAGES   = 2'd1;

	localparam logic [ADDR_W-1:0] BASE_RESET = 32'hC010_0000;
	localparam logic [PAGE_W-1:0] POOL_RESET = 13'd4096;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_MARK_RD,
		ST_MARK_WR,
		ST_FINISH
	} cpba_state_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;       // latch request
		logic fail_set;     // result is a failure
		logic scan_start;   // reset scan pointers
		logic scan_run;     // scan one row per cycle
		logic mark_wr;      // write back marked row
		logic load_out;     // move result into output register
	} cpba_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic count_bad;
		logic scan_hit;
		logic scan_end;
		logic mark_last;
		logic out_free;
	} cpba_status_t;

endpackage

// ===== rtl/cpba_ctrl.sv =====
// Controller state machine of the page allocator.
// Depends on cpba_pkg; drives cpba_datapath through cpba_cmd_t.
module cpba_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  cpba_pkg::cpba_status_t status,
	output cpba_pkg::cpba_cmd_t    cmd
);
	import cpba_pkg::*;

	cpba_state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = status.count_bad ? ST_FINISH : ST_SCAN;
			end
			ST_SCAN: begin
				priority if (status.scan_hit) state_d = ST_MARK_RD;
				else if (status.scan_end)     state_d = ST_FINISH;
				else                          state_d = ST_SCAN;
			end
			ST_MARK_RD: begin
				state_d = ST_MARK_WR;
			end
			ST_MARK_WR: begin
				state_d = status.mark_last ? ST_FINISH : ST_MARK_RD;
			end
			ST_FINISH: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_CHECK: begin
				cmd.fail_set   = status.count_bad;
				cmd.scan_start = !status.count_bad;
			end
			ST_SCAN:    cmd.scan_run = 1'b1;
			ST_MARK_RD: ;
			ST_MARK_WR: cmd.mark_wr = 1'b1;
			ST_FINISH:  cmd.load_out = status.out_free;
			default: ;
		endcase
	end

endmodule

// ===== rtl/cpba_datapath.sv =====
// Datapath of the page allocator: config registers, bitmap rows, scan and
// mark logic, output register. Depends on cpba_pkg.
module cpba_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [cpba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cpba_pkg::CFG_DATA_W-1:0] cfg_wr_data,
	input  logic [cpba_pkg::PAGE_W-1:0]    page_count,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic                           granted,
	output logic [cpba_pkg::ADDR_W-1:0]    start_address,
	input  cpba_pkg::cpba_cmd_t            cmd,
	output cpba_pkg::cpba_status_t         status
);
	import cpba_pkg::*;

	// Config
	logic [ADDR_W-1:0] base_q;
	logic [PAGE_W-1:0] pool_q;
	logic [PAGE_W-1:0] limit;
	logic [PAGE_W-1:0] limit_m1;
	logic [WADDR_W-1:0] last_word;

	// Request and result
	logic [PAGE_W-1:0] count_q;
	logic              granted_q;
	logic [PAGE_W-1:0] start_q;
	logic [PAGE_W-1:0] end_q;

	// Bitmap rows, a row that was never written reads as all free
	logic [WORD_BITS-1:0] mem [NUM_WORDS];
	logic [NUM_WORDS-1:0] row_valid_q;
	logic [WADDR_W-1:0]   rd_addr;
	logic [WORD_BITS-1:0] rdata_s1;
	logic                 rvalid_s1;
	logic [WORD_BITS-1:0] rword;

	// Scan
	logic [WADDR_W-1:0]   scan_addr_q;
	logic [WADDR_W-1:0]   eval_word_s1;
	logic                 eval_vld_s1;
	logic [PAGE_W-1:0]    run_q;
	logic [WORD_BITS-1:0] free_bits;
	logic [PAGE_W-1:0]    run_lane [WORD_BITS];
	logic                 all_free [WORD_BITS];
	logic [CNT_W-1:0]     trail [WORD_BITS];
	logic                 hit;
	logic [LANE_W-1:0]    hit_lane;
	logic [PAGE_W-1:0]    hit_end;
	logic [PAGE_W-1:0]    hit_start;

	// Mark
	logic [WADDR_W-1:0]   mark_addr_q;
	logic [WORD_BITS-1:0] mark_mask;

	// Output register
	logic              out_valid_q;
	logic              out_granted_q;
	logic [ADDR_W-1:0] out_addr_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
			pool_q <= POOL_RESET;
		end else if (cfg_wr_en) begin
			if (cfg_index == REG_VIRTUAL_BASE) base_q <= cfg_wr_data[ADDR_W-1:0];
			if (cfg_index == REG_POOL_PAGES)   pool_q <= cfg_wr_data[PAGE_W-1:0];
		end
	end

	// Pool limit, clamped to the map size
	assign limit     = (pool_q > PAGE_W'(MAX_PAGES)) ? PAGE_W'(MAX_PAGES) : pool_q;
	assign limit_m1  = limit - PAGE_W'(1);
	assign last_word = limit_m1[PG_IDX_W-1:LANE_W];

	// Row memory: one read per cycle, registered
	assign rd_addr = cmd.scan_run ? scan_addr_q : mark_addr_q;

	always_ff @(posedge clk) begin
		rdata_s1 <= mem[rd_addr];
		if (cmd.mark_wr) mem[mark_addr_q] <= rword | mark_mask;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rvalid_s1   <= 1'b0;
		end else begin
			rvalid_s1 <= row_valid_q[rd_addr];
			if (cmd.mark_wr) row_valid_q[mark_addr_q] <= 1'b1;
		end
	end

	assign rword = rvalid_s1 ? rdata_s1 : '0;

	// Per-lane free bits, pages beyond the pool count as used
	always_comb begin
		for (int j = 0; j < WORD_BITS; j++) begin
			free_bits[j] = !rword[j] && ({1'b0, eval_word_s1, LANE_W'(j)} < limit);
		end
	end

	// Free run length ending at each lane
	always_comb begin
		for (int j = 0; j < WORD_BITS; j++) begin
			all_free[j] = 1'b1;
			trail[j]    = CNT_W'(j + 1);
			for (int k = 0; k < WORD_BITS; k++) begin
				if (k <= j && !free_bits[k]) begin
					all_free[j] = 1'b0;
					trail[j]    = CNT_W'(j - k);
				end
			end
			run_lane[j] = all_free[j] ? run_q + PAGE_W'(j + 1) : PAGE_W'(trail[j]);
		end
	end

	// First lane whose run reaches the requested count
	always_comb begin
		hit      = 1'b0;
		hit_lane = '0;
		for (int j = 0; j < WORD_BITS; j++) begin
			if (!hit && free_bits[j] && run_lane[j] == count_q) begin
				hit      = 1'b1;
				hit_lane = LANE_W'(j);
			end
		end
	end

	assign hit_end   = {1'b0, eval_word_s1, hit_lane};
	assign hit_start = hit_end + PAGE_W'(1) - count_q;

	// Scan pointers and running run length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_addr_q  <= '0;
			eval_word_s1 <= '0;
			eval_vld_s1  <= 1'b0;
			run_q        <= '0;
		end else if (cmd.scan_start) begin
			scan_addr_q <= '0;
			eval_vld_s1 <= 1'b0;
			run_q       <= '0;
		end else if (cmd.scan_run) begin
			scan_addr_q  <= scan_addr_q + WADDR_W'(1);
			eval_word_s1 <= scan_addr_q;
			eval_vld_s1  <= 1'b1;
			if (eval_vld_s1) run_q <= run_lane[WORD_BITS-1];
		end
	end

	// Request and result registers
	always_ff @(posedge clk) begin
		if (cmd.accept) count_q <= page_count;
		if (cmd.fail_set) granted_q <= 1'b0;
		if (cmd.scan_run && eval_vld_s1) begin
			if (hit) begin
				granted_q   <= 1'b1;
				start_q     <= hit_start;
				end_q       <= hit_end;
				mark_addr_q <= hit_start[PG_IDX_W-1:LANE_W];
			end else if (eval_word_s1 == last_word) begin
				granted_q <= 1'b0;
			end
		end else if (cmd.mark_wr) begin
			mark_addr_q <= mark_addr_q + WADDR_W'(1);
		end
	end

	// Bits of the current row that fall inside the run
	always_comb begin
		for (int j = 0; j < WORD_BITS; j++) begin
			mark_mask[j] = ({1'b0, mark_addr_q, LANE_W'(j)} >= start_q) &&
			               ({1'b0, mark_addr_q, LANE_W'(j)} <= end_q);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_granted_q <= granted_q;
			out_addr_q    <= granted_q ?
			                 base_q + (ADDR_W'(start_q) << PAGE_SHIFT) : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign granted       = out_granted_q;
	assign start_address = out_addr_q;

	// Status to controller
	assign status.count_bad = (count_q == '0) || (count_q > limit);
	assign status.scan_hit  = eval_vld_s1 && hit;
	assign status.scan_end  = eval_vld_s1 && !hit && (eval_word_s1 == last_word);
	assign status.mark_last = (mark_addr_q == end_q[PG_IDX_W-1:LANE_W]);
	assign status.out_free  = !out_valid_q || out_ready;

endmodule

// ===== rtl/contiguous_page_bitmap_allocator.sv =====
// First-fit contiguous page allocator over a 4096-page use bitmap.
// Channels: request (in_valid/in_ready, page_count) and result (out_valid/
// out_ready, granted, start_address), both valid/ready; a transaction moves
// at a clock edge where valid and ready are both high.
// Config: cfg_wr_en/cfg_index/cfg_wr_data, index 0 = virtual_base,
// index 1 = pool_pages; write only while the block is idle.
// One request is processed at a time. The bitmap is held as 256 rows of 16
// pages in a single-port row memory; the scan reads one row per cycle, up to
// 256 rows, and stops at the first row that completes a run or at the last
// row of the pool; then each row touched by the granted run is read and
// written back. A zero or oversized count fails without a scan. The next
// request can be taken in the cycle after the result is loaded.
// Result lives in an output register: a stalled receiver does not block the
// next request, which finishes its work and then waits for the register.
// Reset: asynchronous, active low. All pages free at once (per-row valid
// bits), base 0xC0100000, pool 4096 pages; no clearing pass.
// Depends on cpba_pkg, cpba_ctrl, cpba_datapath.
module contiguous_page_bitmap_allocator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [cpba_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cpba_pkg::CFG_DATA_W-1:0] cfg_wr_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [cpba_pkg::PAGE_W-1:0]     page_count,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            granted,
	output logic [cpba_pkg::ADDR_W-1:0]     start_address
);
	import cpba_pkg::*;

	cpba_cmd_t    cmd;
	cpba_status_t status;

	cpba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	cpba_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wr_data   (cfg_wr_data),
		.page_count    (page_count),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.granted       (granted),
		.start_address (start_address),
		.cmd           (cmd),
		.status        (status)
	);

endmodule

// ===== tb/page_grant_checker.sv =====
// Checker for the contiguous page bitmap allocator: watches the config port and both
// valid/ready channels, keeps its own first-fit page map and compares every result.
// Depends on cpba_pkg for widths and register indexes.
module page_grant_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [cpba_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cpba_pkg::CFG_DATA_W-1:0] cfg_wr_data,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic [cpba_pkg::PAGE_W-1:0]     page_count,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic                            granted,
	input  logic [cpba_pkg::ADDR_W-1:0]     start_address,
	output int                              fail_count,
	output int                              pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import cpba_pkg::*;

	localparam int PRINT_CAP = 50;

	typedef struct packed {
		logic [PAGE_W-1:0] pages;
		logic              granted;
		logic [ADDR_W-1:0] start_address;
	} grant_t;

	// Predicted state: one use bit per page plus the two registers
	logic              page_in_use [MAX_PAGES];
	logic [ADDR_W-1:0] base_addr;
	logic [PAGE_W-1:0] pool_pages_reg;
	grant_t            due_grants[$];

	task automatic report_mismatch(input string what);
		if (fail_count < PRINT_CAP)
			$display("[%0t] page_grant_checker: %s", $time, what);
		fail_count++;
	endtask

	// First-fit search from page 0; marks the run only when one is found
	function automatic grant_t first_fit(input logic [PAGE_W-1:0] want);
		int                limit;
		int                run;
		int                start;
		int                idx;
		logic [ADDR_W-1:0] offset;
		grant_t            g;
		g = '0;
		g.pages = want;
		limit = (pool_pages_reg > MAX_PAGES) ? MAX_PAGES : int'(pool_pages_reg);
		if (want == 0 || want > limit)
			return g;
		run = 0;
		start = 0;
		for (idx = 0; idx < limit; idx++) begin
			if (page_in_use[idx]) begin
				run = 0;
			end else begin
				if (run == 0)
					start = idx;
				run++;
				if (run == want)
					break;
			end
		end
		if (run != want)
			return g;
		for (idx = start; idx < start + want; idx++)
			page_in_use[idx] = 1'b1;
		offset = start;
		offset = offset << PAGE_SHIFT;
		g.granted = 1'b1;
		g.start_address = base_addr + offset;
		return g;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		grant_t due;
		if (!arst_n) begin
			for (int i = 0; i < MAX_PAGES; i++)
				page_in_use[i] = 1'b0;
			base_addr = BASE_RESET;
			pool_pages_reg = POOL_RESET;
			due_grants.delete();
			pending <= 0;
		end else begin
			// register writes; unknown indexes are dropped
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_VIRTUAL_BASE: base_addr = cfg_wr_data;
					REG_POOL_PAGES:   pool_pages_reg = cfg_wr_data[PAGE_W-1:0];
					default: ;
				endcase
			end
			// result transaction: compare with the oldest prediction
			if (out_valid && out_ready) begin
				if (due_grants.size() == 0) begin
					report_mismatch($sformatf("result with nothing outstanding: granted %b addr %h",
						granted, start_address));
				end else begin
					due = due_grants.pop_front();
					if (granted !== due.granted)
						report_mismatch($sformatf("count %0d: granted %b, predicted %b",
							due.pages, granted, due.granted));
					if (start_address !== due.start_address)
						report_mismatch($sformatf("count %0d: start_address %h, predicted %h",
							due.pages, start_address, due.start_address));
				end
			end
			// request transaction: predict now, map updates in request order
			if (in_valid && in_ready)
				due_grants.push_back(first_fit(page_count));
			pending <= due_grants.size();
		end
	end

endmodule

// ===== tb/contiguous_page_bitmap_allocator_tb.sv =====
// Top of the allocator testbench: clock, reset, config writes, request stimulus with
// bursty valid and a stalling receiver, idle watchdog and the verdict.
// Depends on cpba_pkg, contiguous_page_bitmap_allocator and page_grant_checker.
module contiguous_page_bitmap_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cpba_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
	localparam int RAMP_PHASES     = 10;
	localparam int ITEMS_PER_PHASE = 130;
	localparam int SHRUNK_ITEMS    = 40;
	localparam int TAIL_CYCLES     = 1000;
	localparam int IDLE_LIMIT      = 20000;

	logic                  clk;
	logic                  arst_n      = 1'b0;
	logic                  cfg_wr_en   = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
	logic                  in_valid    = 1'b0;
	logic                  in_ready;
	logic [PAGE_W-1:0]     page_count  = '0;
	logic                  out_valid;
	logic                  out_ready   = 1'b0;
	logic                  granted;
	logic [ADDR_W-1:0]     start_address;

	int fail_count;
	int pending;
	int burst_left;
	int pool_lim;
	int idle_cycles = 0;

	contiguous_page_bitmap_allocator u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.page_count    (page_count),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.granted       (granted),
		.start_address (start_address)
	);

	page_grant_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.page_count    (page_count),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.granted       (granted),
		.start_address (start_address),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Leaves cfg_wr_en high so back-to-back writes need no toggle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wr_data <= data;
		@(posedge clk);
	endtask

	task automatic end_writes();
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_pool(input logic [CFG_DATA_W-1:0] data);
		write_reg(REG_POOL_PAGES, data);
		pool_lim = (data[PAGE_W-1:0] > MAX_PAGES) ? MAX_PAGES : int'(data[PAGE_W-1:0]);
	endtask

	// Drop valid and wait until every predicted result has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending != 0);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 20);
		return $urandom_range(21, 80);
	endfunction

	// Mostly small requests so the pool fills over a phase, plus the failure cases
	function automatic logic [PAGE_W-1:0] pick_count();
		int                r;
		logic [PAGE_W-1:0] c;
		r = $urandom_range(0, 99);
		if (r < 5)
			c = '0;
		else if (r < 10)
			c = PAGE_W'($urandom_range(pool_lim + 1, (1 << PAGE_W) - 1));
		else if (r < 80)
			c = PAGE_W'($urandom_range(1, 4));
		else if (r < 96)
			c = PAGE_W'($urandom_range(5, 24));
		else
			c = PAGE_W'($urandom_range(25, 200));
		return c;
	endfunction

	function automatic logic [ADDR_W-1:0] pick_base();
		logic [ADDR_W-1:0] b;
		case ($urandom_range(0, 3))
			0: b = '0;
			1: begin
				b = $urandom_range(0, 15);
				b = 32'hFFFF_F000 - (b << PAGE_SHIFT);
			end
			2: begin
				b = $urandom;
				b = (b >> PAGE_SHIFT) << PAGE_SHIFT;
			end
			default: b = $urandom;
		endcase
		return b;
	endfunction

	// Sender works in bursts; valid stays high between items inside a burst
	task automatic send_request(input logic [PAGE_W-1:0] cnt);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat (pick_gap()) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		in_valid <= 1'b1;
		page_count <= cnt;
		do @(posedge clk); while (!in_ready);
		burst_left--;
	endtask

	// Receiver: ready windows of random length, short and long stalls between them
	initial begin
		int hold;
		int r;
		@(posedge clk);
		forever begin
			out_ready <= 1'b1;
			hold = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 800) : $urandom_range(1, 40);
			repeat (hold) @(posedge clk);
			out_ready <= 1'b0;
			r = $urandom_range(0, 9);
			if (r < 6)
				hold = $urandom_range(1, 3);
			else if (r < 9)
				hold = $urandom_range(4, 30);
			else
				hold = $urandom_range(31, 200);
			repeat (hold) @(posedge clk);
		end
	end

	// Watchdog: too long without any transaction on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("contiguous_page_bitmap_allocator_tb NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int                    p;
		int                    n;
		logic [CFG_DATA_W-1:0] data;
		burst_left = 0;
		pool_lim = MAX_PAGES;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: zero count, first grant, full-pool count with page 0 taken,
		// a request ending on a row edge, one row-aligned, one crossing rows, no free run
		send_request(13'd0);
		send_request(13'd1);
		send_request(13'd4096);
		send_request(13'd15);
		send_request(13'd16);
		send_request(13'd17);
		send_request(13'd4095);

		// Empty pool, zero base: every count fails, zero or above the pool
		wait_drained();
		write_reg(REG_VIRTUAL_BASE, '0);
		set_pool('0);
		end_writes();
		send_request(13'd1);
		send_request(13'd0);
		send_request(13'd4096);

		// Top-of-space base: the grant address wraps; pool leaves an 11-page hole
		wait_drained();
		write_reg(REG_VIRTUAL_BASE, 32'hFFFF_F000);
		set_pool(32'd60);
		end_writes();
		send_request(13'd12);
		send_request(13'd11);
		send_request(13'd1);
		send_request(13'd61);

		// Pool shrunk below the used pages
		wait_drained();
		set_pool(32'd30);
		end_writes();
		send_request(13'd1);
		send_request(13'd30);
		send_request(13'd31);

		// Oversized pool value clamps, spare indexes are ignored, unaligned base
		wait_drained();
		set_pool(32'hFFFF_FFFF);
		write_reg(REG_SPARE_2, $urandom);
		write_reg(REG_SPARE_3, $urandom);
		write_reg(REG_VIRTUAL_BASE, 32'hFFFF_FFFF);
		end_writes();
		send_request(13'd1);
		send_request(13'd4096);

		// Random part: pool grows phase by phase so each phase fills and then fails
		for (p = 0; p < RAMP_PHASES; p++) begin
			wait_drained();
			write_reg(REG_VIRTUAL_BASE, pick_base());
			data = (p + 1) * MAX_PAGES / RAMP_PHASES;
			if (p == RAMP_PHASES - 1)
				data = $urandom_range(0, 1) ? MAX_PAGES : $urandom_range(MAX_PAGES + 1, 8191);
			if ($urandom_range(0, 3) == 0)
				data |= {$urandom} << PAGE_W;
			set_pool(data);
			end_writes();
			for (n = 0; n < ITEMS_PER_PHASE; n++)
				send_request(pick_count());
			// one shrunk-pool phase midway
			if (p == RAMP_PHASES / 2) begin
				wait_drained();
				set_pool($urandom_range(0, 300));
				end_writes();
				for (n = 0; n < SHRUNK_ITEMS; n++)
					send_request(pick_count());
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("contiguous_page_bitmap_allocator_tb OK");
		else
			$display("contiguous_page_bitmap_allocator_tb NOT OK");
		$finish;
	end

endmodule

// ===== contiguous_page_bitmap_allocator.f =====
rtl/cpba_pkg.sv
rtl/cpba_ctrl.sv
rtl/cpba_datapath.sv
rtl/contiguous_page_bitmap_allocator.sv
tb/page_grant_checker.sv
tb/contiguous_page_bitmap_allocator_tb.sv
